// ===== hdl/rbdq_pkg.sv =====
// Shared types, sizes and operation codes for the ring buffer deque checker.
package rbdq_pkg;

  // Store size and the widths that follow from it.
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  // Operation codes carried in the request.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3
  } op_e;

  // Request payload.
  typedef struct packed {
    logic [2:0]        operation;
    logic [DATA_W-1:0] value;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic              was_empty;
    logic              push_dropped;
    logic              mismatch;
    logic              all_correct;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic finish_pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;
  } status_t;

endpackage

// ===== hdl/rbdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rbdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rbdq_ctrl.sv =====
// Controller state machine that sequences one request at a time.
module rbdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rbdq_pkg::status_t status_i,
  output rbdq_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Handshake outputs follow the state.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);

  assign cmd_o.accept     = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.finish_pop = (state_q == ST_READ);

  // Next state: a pop that hits the store passes through ST_READ to wait for the read data.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.needs_read ? ST_READ : ST_RESP;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/rbdq_datapath.sv =====
// Datapath: deque pointers, element count, correctness flag, store and result.
module rbdq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbdq_pkg::in_t     in_data_i,
  input  rbdq_pkg::cmd_t    cmd_i,
  output rbdq_pkg::status_t status_o,
  output rbdq_pkg::out_t    out_data_o
);

  localparam int unsigned IW = rbdq_pkg::IDX_W;
  localparam int unsigned CW = rbdq_pkg::CNT_W;
  localparam int unsigned DW = rbdq_pkg::DATA_W;

  logic [IW-1:0] front_q, front_d, back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic          correct_q, correct_d;
  logic [DW-1:0] expect_q;
  rbdq_pkg::out_t res_q, res_d;

  logic [IW-1:0] front_prev, front_next, back_prev, back_next;
  logic          empty, full;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [DW-1:0] rdata;
  logic          bad;

  // Circular neighbors of both ends.
  assign front_prev = (front_q == '0) ? IW'(rbdq_pkg::DEPTH - 1) : front_q - 1'b1;
  assign front_next = (front_q == IW'(rbdq_pkg::DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign back_prev  = (back_q == '0) ? IW'(rbdq_pkg::DEPTH - 1) : back_q - 1'b1;
  assign back_next  = (back_q == IW'(rbdq_pkg::DEPTH - 1)) ? '0 : back_q + 1'b1;

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(rbdq_pkg::DEPTH));

  // Decode the request into store accesses and the early result.
  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    correct_d = correct_q;
    res_d     = res_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = back_q;
    raddr     = front_q;
    bad       = 1'b0;
    status_o.needs_read = 1'b0;

    case (in_data_i.operation)
      rbdq_pkg::OP_PUSH_FRONT: begin
        waddr = front_prev;
      end
      rbdq_pkg::OP_PUSH_BACK: begin
        waddr = back_q;
      end
      rbdq_pkg::OP_POP_FRONT: begin
        raddr = front_q;
        status_o.needs_read = !empty;
      end
      rbdq_pkg::OP_POP_BACK: begin
        raddr = back_prev;
        status_o.needs_read = !empty;
      end
      default: begin
        raddr = front_q;
      end
    endcase

    if (cmd_i.accept) begin
      res_d.pop_value    = '0;
      res_d.was_empty    = 1'b0;
      res_d.push_dropped = 1'b0;
      case (in_data_i.operation)
        rbdq_pkg::OP_PUSH_FRONT, rbdq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            res_d.push_dropped = 1'b1;
            bad = 1'b1;
          end else begin
            we      = 1'b1;
            count_d = count_q + 1'b1;
            if (in_data_i.operation == rbdq_pkg::OP_PUSH_FRONT) begin
              front_d = front_prev;
            end else begin
              back_d = back_next;
            end
          end
        end
        rbdq_pkg::OP_POP_FRONT, rbdq_pkg::OP_POP_BACK: begin
          if (empty) begin
            res_d.pop_value = '1;
            res_d.was_empty = 1'b1;
            bad = (in_data_i.value != '1);
          end else begin
            re      = 1'b1;
            count_d = count_q - 1'b1;
            if (in_data_i.operation == rbdq_pkg::OP_POP_FRONT) begin
              front_d = front_next;
            end else begin
              back_d = back_prev;
            end
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      res_d.mismatch    = bad;
      res_d.all_correct = correct_q && !bad;
      correct_d         = correct_q && !bad;
    end

    // The read data of a pop arrives in the cycle after the request is taken.
    if (cmd_i.finish_pop) begin
      res_d.pop_value   = rdata;
      res_d.mismatch    = (rdata != expect_q);
      res_d.all_correct = correct_q && (rdata == expect_q);
      correct_d         = correct_q && (rdata == expect_q);
    end
  end

  // Element store.
  rbdq_ram #(
    .WIDTH(DW),
    .DEPTH(rbdq_pkg::DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      back_q    <= '0;
      count_q   <= '0;
      correct_q <= 1'b1;
    end else begin
      front_q   <= front_d;
      back_q    <= back_d;
      count_q   <= count_d;
      correct_q <= correct_d;
    end
  end

  // Result and expected value need no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.accept) begin
      expect_q <= in_data_i.value;
    end
  end

  assign out_data_o = res_q;

endmodule

// ===== hdl/ring_buffer_deque_checker_core.sv =====
// Top level of the ring buffer deque checker.
//
// Requests arrive on the in channel (valid/ready): an operation code and a
// 32-bit value. Push front and push back store the value; pop front and pop
// back remove an element and compare it with the value. Each request gives
// exactly one result on the out channel (valid/ready) with the popped value,
// empty and dropped flags, a per-request mismatch and the running flag.
// The store holds DEPTH elements in a RAM with a registered read port.
// The result is valid in the cycle after the request for pushes, empty
// pops and invalid codes; a pop that reads the store passes a read state
// first to wait for the RAM read register. One request is in flight at a
// time: no request is taken until the result has been accepted.
// While the receiver stalls the result is held and no request is taken.
// Reset clears both pointers and the element count and sets the running
// flag; the store contents are left as they are, and no clearing pass runs.
module ring_buffer_deque_checker_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rbdq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rbdq_pkg::out_t out_data_o
);

  rbdq_pkg::cmd_t    cmd;
  rbdq_pkg::status_t status;

  // Sequencer.
  rbdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Pointers, store and result register.
  rbdq_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

endmodule

// ===== sim/tb_ring_buffer_deque_checker_core.sv =====
// Self-checking testbench for the ring buffer deque checker core.
module tb_ring_buffer_deque_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes taken from the package.
  localparam int unsigned DEPTH  = rbdq_pkg::DEPTH;
  localparam int unsigned IDX_W  = rbdq_pkg::IDX_W;
  localparam int unsigned CNT_W  = rbdq_pkg::CNT_W;
  localparam int unsigned DATA_W = rbdq_pkg::DATA_W;

  // Highest code the 3-bit operation field can carry; codes past OP_POP_BACK are invalid.
  localparam int unsigned OP_CODE_MAX = 7;
  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rbdq_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rbdq_pkg::out_t out_data_o;

  ring_buffer_deque_checker_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be sent and outcomes waiting to be seen.
  rbdq_pkg::in_t queued_requests[$];
  rbdq_pkg::out_t expected_outcomes[$];
  int unsigned fault_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Contents as the stimulus generator sees them, used to build well-formed pops.
  logic [DATA_W-1:0] tracked_contents[$];

  // Predictor state: circular store, both end pointers, fill level and running flag.
  logic [DATA_W-1:0] ring_store[DEPTH];
  logic [IDX_W-1:0] head_idx = '0;
  logic [IDX_W-1:0] tail_idx = '0;
  logic [CNT_W-1:0] fill_level = '0;
  logic running_ok = 1'b1;

  function automatic logic [IDX_W-1:0] step_fwd(logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_back(logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
  endfunction

  // Apply one accepted request to the predictor and queue the outcome it should give.
  function automatic void apply_deque_request(rbdq_pkg::in_t req);
    rbdq_pkg::out_t res;
    res = '0;
    case (req.operation)
      rbdq_pkg::OP_PUSH_FRONT, rbdq_pkg::OP_PUSH_BACK: begin
        if (fill_level >= CNT_W'(DEPTH)) begin
          res.push_dropped = 1'b1;
          res.mismatch = 1'b1;
        end else if (req.operation == rbdq_pkg::OP_PUSH_FRONT) begin
          head_idx = step_back(head_idx);
          ring_store[head_idx] = req.value;
          fill_level++;
        end else begin
          ring_store[tail_idx] = req.value;
          tail_idx = step_fwd(tail_idx);
          fill_level++;
        end
      end
      rbdq_pkg::OP_POP_FRONT, rbdq_pkg::OP_POP_BACK: begin
        if (fill_level == '0) begin
          res.pop_value = EMPTY_WORD;
          res.was_empty = 1'b1;
        end else if (req.operation == rbdq_pkg::OP_POP_FRONT) begin
          res.pop_value = ring_store[head_idx];
          head_idx = step_fwd(head_idx);
          fill_level--;
        end else begin
          tail_idx = step_back(tail_idx);
          res.pop_value = ring_store[tail_idx];
          fill_level--;
        end
        res.mismatch = (res.pop_value != req.value);
      end
      default: res.mismatch = 1'b1;
    endcase
    if (res.mismatch) running_ok = 1'b0;
    res.all_correct = running_ok;
    expected_outcomes.push_back(res);
  endfunction

  function automatic void check_field(string field_name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field_name, want, got);
      fault_count++;
    end
  endfunction

  // Request driver: keeps valid and payload steady until the handshake completes.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) apply_deque_request(in_data_i);
      if (!in_valid_i || taken) begin
        if (queued_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i <= queued_requests.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest outcome.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    rbdq_pkg::out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding: %p", out_data_o);
          fault_count++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("pop_value", want.pop_value, out_data_o.pop_value);
          check_field("was_empty", DATA_W'(want.was_empty),
                      DATA_W'(out_data_o.was_empty));
          check_field("push_dropped", DATA_W'(want.push_dropped),
                      DATA_W'(out_data_o.push_dropped));
          check_field("mismatch", DATA_W'(want.mismatch),
                      DATA_W'(out_data_o.mismatch));
          check_field("all_correct", DATA_W'(want.all_correct),
                      DATA_W'(out_data_o.all_correct));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Queue one request and keep the generator's view of the contents in step.
  task automatic add_request(logic [2:0] op_code, logic [DATA_W-1:0] val);
    rbdq_pkg::in_t req;
    req.operation = op_code;
    req.value = val;
    case (op_code)
      rbdq_pkg::OP_PUSH_FRONT:
        if (tracked_contents.size() < DEPTH) tracked_contents.push_front(val);
      rbdq_pkg::OP_PUSH_BACK:
        if (tracked_contents.size() < DEPTH) tracked_contents.push_back(val);
      rbdq_pkg::OP_POP_FRONT:
        if (tracked_contents.size() > 0) void'(tracked_contents.pop_front());
      rbdq_pkg::OP_POP_BACK:
        if (tracked_contents.size() > 0) void'(tracked_contents.pop_back());
      default: ;
    endcase
    queued_requests.push_back(req);
  endtask

  // A pop that expects the right value, or a single flipped bit when corrupted.
  task automatic add_pop(bit at_front, bit corrupt);
    logic [DATA_W-1:0] val;
    if (tracked_contents.size() == 0) val = EMPTY_WORD;
    else if (at_front) val = tracked_contents[0];
    else val = tracked_contents[$];
    if (corrupt) val ^= DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    add_request(at_front ? rbdq_pkg::OP_POP_FRONT : rbdq_pkg::OP_POP_BACK, val);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic add_push();
    add_request($urandom_range(0, 1) ? rbdq_pkg::OP_PUSH_BACK : rbdq_pkg::OP_PUSH_FRONT,
                rand_word());
  endtask

  // Mixed traffic: pushes, well-formed pops, and a share of noise.
  task automatic add_mixed(int unsigned count, int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) add_push();
      else if (roll < push_pct + pop_pct)
        add_pop(1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 4));
      else if ($urandom_range(0, 1))
        add_request(3'($urandom_range(rbdq_pkg::OP_POP_BACK + 1, OP_CODE_MAX)), $urandom);
      else
        add_request($urandom_range(0, 1) ? rbdq_pkg::OP_POP_FRONT : rbdq_pkg::OP_POP_BACK,
                    $urandom);
    end
  endtask

  // Let every queued request go through and every outcome arrive.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || expected_outcomes.size() != 0);
  endtask

  initial begin : stimulus
    send_idle_pct = 21;
    recv_idle_pct = 73;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pops, extreme values, both ends, crossing ends, then errors.
    add_pop(1'b1, 1'b0);
    add_pop(1'b0, 1'b0);
    add_request(rbdq_pkg::OP_PUSH_FRONT, '0);
    add_request(rbdq_pkg::OP_PUSH_BACK, '1);
    add_request(rbdq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
    add_request(rbdq_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
    add_pop(1'b1, 1'b0);
    add_pop(1'b0, 1'b0);
    add_pop(1'b0, 1'b0);
    add_pop(1'b1, 1'b0);
    add_request(rbdq_pkg::OP_PUSH_BACK, 32'h0000_0001);
    add_request(rbdq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    add_pop(1'b1, 1'b0);
    add_pop(1'b0, 1'b0);
    add_request(rbdq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
    add_pop(1'b0, 1'b0);
    add_request(rbdq_pkg::OP_POP_FRONT, '0);
    add_request(rbdq_pkg::OP_PUSH_BACK, 32'h0000_0007);
    add_pop(1'b0, 1'b1);
    for (int unsigned code = rbdq_pkg::OP_POP_BACK + 1; code <= OP_CODE_MAX; code++)
      add_request(code[2:0], rand_word());

    // Random traffic around a small fill level.
    add_mixed(12, 45, 45);
    wait_drained();

    // Fill the lower half of the store with a slow sender.
    send_idle_pct = 73;
    recv_idle_pct = 21;
    while (tracked_contents.size() < DEPTH / 2) add_push();
    wait_drained();

    // Fill to the top with no idling, push against it, and work at the boundary.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (tracked_contents.size() < DEPTH) add_push();
    repeat (6) add_push();
    add_pop(1'($urandom_range(0, 1)), 1'b0);
    add_push();
    add_push();
    add_mixed(12, 30, 62);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && expected_outcomes.size() == 0) begin
      $display("[ring_buffer_deque_checker_core] OK");
    end else begin
      $display("[ring_buffer_deque_checker_core] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("[ring_buffer_deque_checker_core] ERROR");
    $finish;
  end

endmodule
